/* rtl/ddsp_pkg.sv */
// Shared constants, payload types and register codes of the dual delay stereo panner.
`default_nettype none
package ddsp_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int MAX_DELAY_SAMPLES = 65536;
    localparam int DELAY_BITS        = 16;
    localparam int COEF_BITS         = 17;
    localparam int DRY_BITS          = 15;
    localparam int FRAC_BITS         = 14;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 17;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_ONE_DELAY      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_TWO_DELAY      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_ONE_LEFT_COEF  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_ONE_RIGHT_COEF = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_TWO_LEFT_COEF  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_TWO_RIGHT_COEF = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRY_COEF           = 3'd6;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in_item;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_item;

    typedef struct packed {
        logic [COEF_BITS-1:0] t1_left;
        logic [COEF_BITS-1:0] t1_right;
        logic [COEF_BITS-1:0] t2_left;
        logic [COEF_BITS-1:0] t2_right;
        logic [DRY_BITS-1:0]  dry;
    } t_mix_coef;

    // fwd: delay is zero, take the sample being written; hit: entry written since reset
    typedef struct packed {
        logic fwd;
        logic hit;
    } t_tap_flags;

endpackage
`default_nettype wire

/* rtl/ddsp_tap_addr.sv */
// Tap address generator: delay clamp, circular address and fill-count check.
`default_nettype none
module ddsp_tap_addr #(
    parameter int   MAX_DELAY_SAMPLES = ddsp_pkg::MAX_DELAY_SAMPLES,
    localparam int  ADDR_BITS         = $clog2(MAX_DELAY_SAMPLES)
) (
    input  logic [ddsp_pkg::DELAY_BITS-1:0] i_delay,
    input  logic [ADDR_BITS-1:0]            i_wr_pos,
    input  logic                            i_wrapped,
    output logic [ADDR_BITS-1:0]            o_addr,
    output ddsp_pkg::t_tap_flags            o_flags
);
    import ddsp_pkg::*;

    localparam int CW  = (ADDR_BITS > DELAY_BITS) ? ADDR_BITS + 1 : DELAY_BITS + 1;
    localparam int AW1 = ADDR_BITS + 1;
    localparam logic [CW-1:0]  DLIM  = CW'(MAX_DELAY_SAMPLES - 1);
    localparam logic [AW1-1:0] DEPTH = AW1'(MAX_DELAY_SAMPLES);

    logic [CW-1:0]        d_ext;
    logic [ADDR_BITS-1:0] d_sat;
    logic [AW1-1:0]       diff;
    logic [AW1-1:0]       wrap_sum;

    always_comb begin
        d_ext = CW'(i_delay);
        if (d_ext > DLIM) begin
            d_sat = ADDR_BITS'(DLIM);
        end else begin
            d_sat = ADDR_BITS'(d_ext);
        end
        diff     = {1'b0, i_wr_pos} - {1'b0, d_sat};
        wrap_sum = diff + DEPTH;
        // wrap below zero back into the store
        if (diff[ADDR_BITS]) begin
            o_addr = wrap_sum[ADDR_BITS-1:0];
        end else begin
            o_addr = diff[ADDR_BITS-1:0];
        end
        o_flags.fwd = (d_sat == '0);
        o_flags.hit = i_wrapped || (o_addr < i_wr_pos);
    end

endmodule
`default_nettype wire

/* rtl/ddsp_delay_mem.sv */
// Mono history store: one write port and one registered read port.
`default_nettype none
module ddsp_delay_mem #(
    parameter int  MAX_DELAY_SAMPLES = ddsp_pkg::MAX_DELAY_SAMPLES,
    localparam int ADDR_BITS         = $clog2(MAX_DELAY_SAMPLES)
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [ADDR_BITS-1:0]    i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [ADDR_BITS-1:0]    i_wr_addr,
    input  ddsp_pkg::t_sample       i_wr_data,
    output ddsp_pkg::t_sample       o_rd_data
);
    import ddsp_pkg::*;

    t_sample r_mem [MAX_DELAY_SAMPLES];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* rtl/ddsp_mix.sv */
// Mixer: registered products, then sum, round and saturate into the output register.
`default_nettype none
module ddsp_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    output logic                o_ready,
    input  ddsp_pkg::t_sample   i_t1,
    input  ddsp_pkg::t_sample   i_t2,
    input  ddsp_pkg::t_sample   i_left,
    input  ddsp_pkg::t_sample   i_right,
    input  ddsp_pkg::t_mix_coef i_coef,
    output logic                o_valid,
    input  logic                i_stall,
    output ddsp_pkg::t_out_item o_item
);
    import ddsp_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS + 1;
    localparam int DW = SAMPLE_BITS + DRY_BITS + 1;
    localparam int AW = PW + 2;
    localparam int QW = AW - FRAC_BITS;
    localparam logic signed [AW-1:0] HALF = AW'(2 ** (FRAC_BITS - 1));
    localparam logic signed [QW-1:0] QHI  = QW'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [QW-1:0] QLO  = ~QHI;

    function automatic t_sample f_round_sat(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic signed [DW-1:0] c
    );
        logic signed [AW-1:0] acc;
        logic signed [QW-1:0] q;
        t_sample              res;
        acc = AW'(a) + AW'(b) + AW'(c) + HALF;
        q   = QW'(acc >>> FRAC_BITS);
        if (q > QHI) begin
            res = SAMPLE_BITS'(QHI);
        end else if (q < QLO) begin
            res = SAMPLE_BITS'(QLO);
        end else begin
            res = SAMPLE_BITS'(q);
        end
        return res;
    endfunction

    logic                 r_m_valid;
    logic signed [PW-1:0] r_p1l, r_p1r, r_p2l, r_p2r;
    logic signed [DW-1:0] r_pdl, r_pdr;
    logic                 r_o_valid;
    t_out_item            r_out;
    logic                 out_free;

    assign out_free = !r_o_valid || !i_stall;
    assign o_ready  = !r_m_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_m_valid <= i_load;
            end
            if (out_free) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_p1l <= $signed(i_t1) * $signed({1'b0, i_coef.t1_left});
            r_p1r <= $signed(i_t1) * $signed({1'b0, i_coef.t1_right});
            r_p2l <= $signed(i_t2) * $signed({1'b0, i_coef.t2_left});
            r_p2r <= $signed(i_t2) * $signed({1'b0, i_coef.t2_right});
            r_pdl <= $signed(i_left) * $signed({1'b0, i_coef.dry});
            r_pdr <= $signed(i_right) * $signed({1'b0, i_coef.dry});
        end
        if (out_free && r_m_valid) begin
            r_out.left_out  <= f_round_sat(r_p1l, r_p2l, r_pdl);
            r_out.right_out <= f_round_sat(r_p1r, r_p2r, r_pdr);
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

/* rtl/dual_delay_stereo_panner.sv */
// Top level of the dual delay stereo panner: sequencer, config registers, store and mixer.
// Result path: r_ph1, r_ph2, then the mixer's product and output registers.
// The history store's single read port takes the tap one read in the accept cycle and the
//   tap two read (plus the write) in the next, so a new item waits out the tap two phase.
// Reset: control and config registers clear; the history store is not swept. A write
//   pointer with a wrap flag marks written entries, and unwritten entries read as zero.
`default_nettype none
module dual_delay_stereo_panner #(
    parameter int MAX_DELAY_SAMPLES = ddsp_pkg::MAX_DELAY_SAMPLES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  ddsp_pkg::t_in_item                   i_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output ddsp_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [ddsp_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [ddsp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import ddsp_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_DELAY_SAMPLES);
    localparam logic [ADDR_BITS-1:0] LAST_POS = ADDR_BITS'(MAX_DELAY_SAMPLES - 1);

    // configuration registers
    logic [DELAY_BITS-1:0] r_tap_one_delay;
    logic [DELAY_BITS-1:0] r_tap_two_delay;
    t_mix_coef             r_coef;

    // sequencer: r_ph1 = tap one read done, tap two read and write due;
    // r_ph2 = tap two data on the read port, waiting for the mixer
    logic                  r_ph1;
    logic                  r_ph2;
    logic [ADDR_BITS-1:0]  r_wr_pos;
    logic                  r_wrapped;

    // item payload held through both phases
    t_sample               r_left;
    t_sample               r_right;
    t_sample               r_mono;
    t_sample               r_t1;
    t_tap_flags            r_t1_flags;
    t_tap_flags            r_t2_flags;

    logic                  accept;
    logic                  mix_ready;
    logic [DELAY_BITS-1:0] tap_delay;
    logic [ADDR_BITS-1:0]  tap_addr;
    t_tap_flags            tap_flags;
    t_sample               rd_data;
    t_sample               t1_val;
    t_sample               t2_val;
    logic signed [SAMPLE_BITS:0] lr_sum;
    t_sample               mono;

    // Accept only when no item sits in the tap two phase and the read port data
    // of an older item is either absent or leaving for the mixer this cycle.
    assign o_stall = r_ph1 || (r_ph2 && !mix_ready);
    assign accept  = i_valid && !o_stall;

    // Floor average: sign-extend, add, drop the low bit.
    assign lr_sum = {i_in.left_in[SAMPLE_BITS-1], i_in.left_in}
                  + {i_in.right_in[SAMPLE_BITS-1], i_in.right_in};
    assign mono   = lr_sum[SAMPLE_BITS:1];

    // One address generator serves both taps: tap one in the accept cycle,
    // tap two in the following cycle. The write pointer moves only after both.
    assign tap_delay = r_ph1 ? r_tap_two_delay : r_tap_one_delay;

    ddsp_tap_addr #(
        .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES)
    ) u_tap_addr (
        .i_delay   (tap_delay),
        .i_wr_pos  (r_wr_pos),
        .i_wrapped (r_wrapped),
        .o_addr    (tap_addr),
        .o_flags   (tap_flags)
    );

    // Tap two reads in the same cycle as the write, and only at the same entry for a
    // zero delay: a nonzero clamped delay always lands behind the write pointer, and a
    // zero delay is taken from the mono register instead of the store.
    ddsp_delay_mem #(
        .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES)
    ) u_delay_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept || r_ph1),
        .i_rd_addr (tap_addr),
        .i_wr_en   (r_ph1),
        .i_wr_addr (r_wr_pos),
        .i_wr_data (r_mono),
        .o_rd_data (rd_data)
    );

    // Forward the current sample for a zero delay; read zero from entries not yet written.
    always_comb begin
        if (r_t1_flags.fwd) begin
            t1_val = r_mono;
        end else if (r_t1_flags.hit) begin
            t1_val = rd_data;
        end else begin
            t1_val = '0;
        end
        if (r_t2_flags.fwd) begin
            t2_val = r_mono;
        end else if (r_t2_flags.hit) begin
            t2_val = rd_data;
        end else begin
            t2_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_one_delay <= '0;
            r_tap_two_delay <= '0;
            r_coef          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TAP_ONE_DELAY:      r_tap_one_delay <= i_cfg_data[DELAY_BITS-1:0];
                CFG_TAP_TWO_DELAY:      r_tap_two_delay <= i_cfg_data[DELAY_BITS-1:0];
                CFG_TAP_ONE_LEFT_COEF:  r_coef.t1_left  <= i_cfg_data[COEF_BITS-1:0];
                CFG_TAP_ONE_RIGHT_COEF: r_coef.t1_right <= i_cfg_data[COEF_BITS-1:0];
                CFG_TAP_TWO_LEFT_COEF:  r_coef.t2_left  <= i_cfg_data[COEF_BITS-1:0];
                CFG_TAP_TWO_RIGHT_COEF: r_coef.t2_right <= i_cfg_data[COEF_BITS-1:0];
                CFG_DRY_COEF:           r_coef.dry      <= i_cfg_data[DRY_BITS-1:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1     <= 1'b0;
            r_ph2     <= 1'b0;
            r_wr_pos  <= '0;
            r_wrapped <= 1'b0;
        end else begin
            r_ph1 <= accept;
            r_ph2 <= r_ph1 || (r_ph2 && !mix_ready);
            // advance the write pointer once the item is written
            if (r_ph1) begin
                if (r_wr_pos == LAST_POS) begin
                    r_wr_pos  <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wr_pos <= r_wr_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left     <= i_in.left_in;
            r_right    <= i_in.right_in;
            r_mono     <= mono;
            r_t1_flags <= tap_flags;
        end
        if (r_ph1) begin
            r_t1       <= t1_val;
            r_t2_flags <= tap_flags;
        end
    end

    // Tap two data is consumed straight off the read port while r_ph2 holds.
    ddsp_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_ph2),
        .o_ready (mix_ready),
        .i_t1    (r_t1),
        .i_t2    (t2_val),
        .i_left  (r_left),
        .i_right (r_right),
        .i_coef  (r_coef),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_out)
    );

endmodule
`default_nettype wire
